>>> rtl/lattice_site_to_node_and_index_core_defines.svh
// Assertion macros shared by the lattice site decomposition RTL.
// Depends on nothing; included by files that carry assertions.
`ifndef LATTICE_SITE_TO_NODE_AND_INDEX_CORE_DEFINES_SVH
`define LATTICE_SITE_TO_NODE_AND_INDEX_CORE_DEFINES_SVH

// Assert an implication on every clock edge outside reset.
`define LSNI_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Assert an implication checked in the cycle after the antecedent, outside reset.
`define LSNI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> rtl/lsni_pkg.sv
// Package for the lattice site decomposition core: sizes, widths, cell payload type.
// Depends on nothing.
package lsni_pkg;
    localparam int NUM_DIMS = 4;
    localparam int MAX_DIMS = 4;
    localparam int CW = 12;      // coordinate width
    localparam int SW = 7;       // size register width
    localparam int NW = 6;       // node coordinate width
    localparam int OW = 24;      // linear index width
    localparam int NUM_REGS = 8;

    localparam logic [2:0] REG_SUBGRID_0 = 3'd0;
    localparam logic [2:0] REG_MACHINE_0 = 3'd4;

    // Payload handed from one cell to the next.
    typedef struct packed {
        logic                valid;
        logic                bad;
        logic [OW-1:0]       node;
        logic [OW-1:0]       local_idx;
        logic [MAX_DIMS-1:0][NW-1:0] nc;
        logic [MAX_DIMS-1:0][CW-1:0] coord;
    } t_beat;

    // Clamp a size register: zero acts as one, above 64 acts as 64.
    function automatic logic [SW-1:0] eff_size(input logic [SW-1:0] v);
        logic [SW-1:0] r;
        begin
            r = v;
            if (v == '0) r = SW'(1);
            else if (v > SW'(64)) r = SW'(64);
            return r;
        end
    endfunction
endpackage

>>> rtl/lattice_site_to_node_and_index_core.sv
// Top level of the lattice site decomposition core: config registers, cell chains, output.
// Depends on lsni_pkg, lsni_divider_cell, lsni_linear_cell and the defines header.
//
// channel | direction | handshake             | payload
// item    | in        | i_start & !o_busy     | i_coord_0..3
// result  | out       | o_done strobe         | o_node_number, o_local_index, o_node_coord_0..3,
//         |           |                       | o_out_of_range
// config  | in        | i_cfg_valid & o_cfg_ready | i_cfg_index, i_cfg_data
//
// One item per cycle; o_busy is always low. A result passes one input register,
// twelve divider cells (one quotient bit each), four linearizing cells and the output
// register.
// Reset clears all valid bits and loads every size register with 1.
// The receiver cannot stall; results are never held.
`include "lattice_site_to_node_and_index_core_defines.svh"
module lattice_site_to_node_and_index_core
    import lsni_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    output logic          o_busy,
    input  logic [CW-1:0] i_coord_0,
    input  logic [CW-1:0] i_coord_1,
    input  logic [CW-1:0] i_coord_2,
    input  logic [CW-1:0] i_coord_3,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [2:0]    i_cfg_index,
    input  logic [SW-1:0] i_cfg_data,
    output logic          o_done,
    output logic [OW-1:0] o_node_number,
    output logic [OW-1:0] o_local_index,
    output logic [NW-1:0] o_node_coord_0,
    output logic [NW-1:0] o_node_coord_1,
    output logic [NW-1:0] o_node_coord_2,
    output logic [NW-1:0] o_node_coord_3,
    output logic          o_out_of_range
);
    logic [NUM_REGS-1:0][SW-1:0]  r_cfg;
    logic [MAX_DIMS-1:0][SW-1:0]  sg, ms;
    logic [MAX_DIMS-1:0][2*SW-1:0] ext;

    assign o_busy      = 1'b0;
    assign o_cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_REGS; i++) r_cfg[i] <= SW'(1);
        end else if (i_cfg_valid) begin
            r_cfg[i_cfg_index] <= i_cfg_data;
        end
    end

    // Clamped sizes and extents, taken straight from the size registers.
    always_comb begin
        for (int d = 0; d < MAX_DIMS; d++) begin
            sg[d]  = eff_size(r_cfg[REG_SUBGRID_0 + 3'(d)]);
            ms[d]  = eff_size(r_cfg[REG_MACHINE_0 + 3'(d)]);
            ext[d] = sg[d] * ms[d];
        end
    end

    // Input register with range check; unused dimensions are zeroed.
    logic                        r_in_valid, r_in_bad;
    logic [MAX_DIMS-1:0][CW-1:0] r_in_coord, in_coord;
    logic                        in_bad;

    always_comb begin
        in_coord[0] = i_coord_0;
        in_coord[1] = i_coord_1;
        in_coord[2] = i_coord_2;
        in_coord[3] = i_coord_3;
        in_bad = 1'b0;
        for (int d = 0; d < MAX_DIMS; d++) begin
            if (d >= NUM_DIMS) in_coord[d] = '0;
            else if ((2*SW)'(in_coord[d]) >= ext[d]) in_bad = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= i_start && !o_busy;
        end
        r_in_coord <= in_coord;
        r_in_bad   <= in_bad;
    end

    // Divider chain: one cell per quotient bit, most significant first.
    logic [CW:0]                         dv;
    logic [CW:0]                         db;
    logic [CW:0][MAX_DIMS-1:0][CW-1:0]   drem, dquo;

    assign dv[0]   = r_in_valid;
    assign db[0]   = r_in_bad;
    assign drem[0] = r_in_coord;
    assign dquo[0] = '0;

    for (genvar k = 0; k < CW; k++) begin : g_div
        lsni_divider_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_div   (sg),
            .i_bit   (4'(CW - 1 - k)),
            .i_valid (dv[k]),
            .i_rem   (drem[k]),
            .i_quo   (dquo[k]),
            .i_bad   (db[k]),
            .o_valid (dv[k+1]),
            .o_rem   (drem[k+1]),
            .o_quo   (dquo[k+1]),
            .o_bad   (db[k+1])
        );
    end

    // Linearizing chain, highest dimension first.
    t_beat [NUM_DIMS:0] lb;

    assign lb[0].valid     = dv[CW];
    assign lb[0].bad       = db[CW];
    assign lb[0].node      = '0;
    assign lb[0].local_idx = '0;
    assign lb[0].coord     = drem[CW];
    for (genvar d = 0; d < MAX_DIMS; d++) begin : g_nc
        assign lb[0].nc[d] = NW'(dquo[CW][d]);
    end

    for (genvar k = 0; k < NUM_DIMS; k++) begin : g_lin
        lsni_linear_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_dim   (2'(NUM_DIMS - 1 - k)),
            .i_ms    (ms[NUM_DIMS - 1 - k]),
            .i_sg    (sg[NUM_DIMS - 1 - k]),
            .i_beat  (lb[k]),
            .o_beat  (lb[k+1])
        );
    end

    // Output register; an out-of-range item shows zeros.
    t_beat r_out;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out.valid <= 1'b0;
        end else begin
            r_out.valid <= lb[NUM_DIMS].valid;
        end
        r_out.bad       <= lb[NUM_DIMS].bad;
        r_out.node      <= lb[NUM_DIMS].bad ? '0 : lb[NUM_DIMS].node;
        r_out.local_idx <= lb[NUM_DIMS].bad ? '0 : lb[NUM_DIMS].local_idx;
        r_out.nc        <= lb[NUM_DIMS].bad ? '0 : lb[NUM_DIMS].nc;
        r_out.coord     <= '0;
    end

    assign o_done         = r_out.valid;
    assign o_node_number  = r_out.node;
    assign o_local_index  = r_out.local_idx;
    assign o_node_coord_0 = r_out.nc[0];
    assign o_node_coord_1 = r_out.nc[1];
    assign o_node_coord_2 = r_out.nc[2];
    assign o_node_coord_3 = r_out.nc[3];
    assign o_out_of_range = r_out.bad;

    `LSNI_ASSERT_NEXT(a_in_to_div, i_clk, i_rst_n, i_start && !o_busy, r_in_valid)
    `LSNI_ASSERT_IMP(a_bad_zero, i_clk, i_rst_n, o_done && o_out_of_range,
        o_node_number == '0 && o_local_index == '0)
    `LSNI_ASSERT_IMP(a_good_nc, i_clk, i_rst_n, o_done && !o_out_of_range,
        o_node_coord_0 < ms[0] && o_node_coord_1 < ms[1])
endmodule

>>> rtl/lsni_divider_cell.sv
// One quotient-bit step of a restoring division over all dimensions.
// Depends on lsni_pkg.
module lsni_divider_cell
    import lsni_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [MAX_DIMS-1:0][SW-1:0]   i_div,
    input  logic [3:0]                    i_bit,
    input  logic                          i_valid,
    input  logic [MAX_DIMS-1:0][CW-1:0]   i_rem,
    input  logic [MAX_DIMS-1:0][CW-1:0]   i_quo,
    input  logic                          i_bad,
    output logic                          o_valid,
    output logic [MAX_DIMS-1:0][CW-1:0]   o_rem,
    output logic [MAX_DIMS-1:0][CW-1:0]   o_quo,
    output logic                          o_bad
);
    logic                        r_valid;
    logic [MAX_DIMS-1:0][CW-1:0] r_rem, n_rem, r_quo, n_quo;
    logic                        r_bad;

    // Try subtracting the shifted divisor in every dimension.
    always_comb begin
        logic [CW+SW-1:0] sh;
        for (int d = 0; d < MAX_DIMS; d++) begin
            sh = (CW+SW)'(i_div[d]) << i_bit;
            n_rem[d] = i_rem[d];
            n_quo[d] = i_quo[d];
            if ((CW+SW)'(i_rem[d]) >= sh) begin
                n_rem[d] = i_rem[d] - CW'(sh);
                n_quo[d][i_bit] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_bad <= i_bad;
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_quo   = r_quo;
    assign o_bad   = r_bad;
endmodule

>>> rtl/lsni_linear_cell.sv
// One Horner step of both linearizations, dimension taken from high to low.
// Depends on lsni_pkg.
module lsni_linear_cell
    import lsni_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [1:0]    i_dim,
    input  logic [SW-1:0] i_ms,
    input  logic [SW-1:0] i_sg,
    input  t_beat         i_beat,
    output t_beat         o_beat
);
    t_beat r_beat, n_beat;

    // node = node*ms + nc, local = local*sg + lc.
    always_comb begin
        n_beat = i_beat;
        n_beat.node = OW'(i_beat.node * i_ms) + OW'(i_beat.nc[i_dim]);
        n_beat.local_idx = OW'(i_beat.local_idx * i_sg) + OW'(i_beat.coord[i_dim]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beat.valid <= 1'b0;
        end else begin
            r_beat.valid <= n_beat.valid;
        end
        r_beat.bad       <= n_beat.bad;
        r_beat.node      <= n_beat.node;
        r_beat.local_idx <= n_beat.local_idx;
        r_beat.nc        <= n_beat.nc;
        r_beat.coord     <= n_beat.coord;
    end

    assign o_beat = r_beat;
endmodule

>>> bench/tb_lattice_site_to_node_and_index_core.sv
// Self-checking bench for the lattice site decomposition core.
// Depends on lsni_pkg and lattice_site_to_node_and_index_core.
`timescale 1ns / 1ps

module tb_lattice_site_to_node_and_index_core;
    import lsni_pkg::*;

    localparam int LATENCY_WAIT = 25;
    localparam int STALL_LIMIT  = 5000;

    typedef struct packed {
        logic [OW-1:0] node;
        logic [OW-1:0] local_idx;
        logic [NW-1:0] nc0;
        logic [NW-1:0] nc1;
        logic [NW-1:0] nc2;
        logic [NW-1:0] nc3;
        logic          bad;
    } t_site;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_start = 1'b0;
    logic          o_busy;
    logic [CW-1:0] i_coord_0 = '0;
    logic [CW-1:0] i_coord_1 = '0;
    logic [CW-1:0] i_coord_2 = '0;
    logic [CW-1:0] i_coord_3 = '0;
    logic          i_cfg_valid = 1'b0;
    logic          o_cfg_ready;
    logic [2:0]    i_cfg_index = '0;
    logic [SW-1:0] i_cfg_data = '0;
    logic          o_done;
    logic [OW-1:0] o_node_number;
    logic [OW-1:0] o_local_index;
    logic [NW-1:0] o_node_coord_0;
    logic [NW-1:0] o_node_coord_1;
    logic [NW-1:0] o_node_coord_2;
    logic [NW-1:0] o_node_coord_3;
    logic          o_out_of_range;

    // Shadow copy of the size registers.
    logic [SW-1:0] subgrid_reg [MAX_DIMS];
    logic [SW-1:0] machine_reg [MAX_DIMS];
    t_site         pending_sites [$];
    int            error_count = 0;
    int            quiet_cycles = 0;

    lattice_site_to_node_and_index_core dut (.*);

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Size as the hardware uses it: zero acts as one, above 64 as 64.
    function automatic int clamp_size(input logic [SW-1:0] v);
        if (v == 0) return 1;
        if (v > 64) return 64;
        return int'(v);
    endfunction

    function automatic int extent_of(input int d);
        return clamp_size(subgrid_reg[d]) * clamp_size(machine_reg[d]);
    endfunction

    // Predict node number, local index and node coordinates of one site.
    function automatic t_site locate_site(input logic [CW-1:0] c0, input logic [CW-1:0] c1,
                                          input logic [CW-1:0] c2, input logic [CW-1:0] c3);
        int    coord [MAX_DIMS];
        int    nc [MAX_DIMS];
        int    lc [MAX_DIMS];
        int    sg;
        int    ms;
        int    node;
        int    loc;
        bit    bad;
        t_site r;
        coord[0] = c0; coord[1] = c1; coord[2] = c2; coord[3] = c3;
        bad = 1'b0;
        node = 0;
        loc = 0;
        for (int d = 0; d < MAX_DIMS; d++) begin
            nc[d] = 0;
            lc[d] = 0;
        end
        for (int d = 0; d < NUM_DIMS; d++) begin
            sg = clamp_size(subgrid_reg[d]);
            if (coord[d] >= extent_of(d)) bad = 1'b1;
            nc[d] = coord[d] / sg;
            lc[d] = coord[d] % sg;
        end
        r = '0;
        if (bad) begin
            r.bad = 1'b1;
            return r;
        end
        for (int d = NUM_DIMS - 1; d >= 0; d--) begin
            sg = clamp_size(subgrid_reg[d]);
            ms = clamp_size(machine_reg[d]);
            node = node * ms + nc[d];
            loc = loc * sg + lc[d];
        end
        r.node = OW'(node);
        r.local_idx = OW'(loc);
        r.nc0 = NW'(nc[0]);
        r.nc1 = NW'(nc[1]);
        r.nc2 = NW'(nc[2]);
        r.nc3 = NW'(nc[3]);
        return r;
    endfunction

    // Track register writes and accepted items at each edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int d = 0; d < MAX_DIMS; d++) begin
                subgrid_reg[d] <= SW'(1);
                machine_reg[d] <= SW'(1);
            end
        end else begin
            if (i_start && !o_busy)
                pending_sites.push_back(locate_site(i_coord_0, i_coord_1, i_coord_2, i_coord_3));
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index < REG_MACHINE_0)
                    subgrid_reg[i_cfg_index[1:0]] <= i_cfg_data;
                else
                    machine_reg[i_cfg_index[1:0]] <= i_cfg_data;
            end
        end
    end

    task automatic check_field(input string name, input int expv, input int actv);
        if (expv !== actv) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, expv, actv);
            error_count++;
        end
    endtask

    // Compare each result beat with the oldest prediction.
    always @(posedge i_clk) begin
        t_site e;
        if (i_rst_n && o_done) begin
            if (pending_sites.size() == 0) begin
                $display("%0t: unexpected result beat, expected none, actual node %0d",
                         $time, o_node_number);
                error_count++;
            end else begin
                e = pending_sites.pop_front();
                check_field("node_number", e.node, o_node_number);
                check_field("local_index", e.local_idx, o_local_index);
                check_field("node_coord_0", e.nc0, o_node_coord_0);
                check_field("node_coord_1", e.nc1, o_node_coord_1);
                check_field("node_coord_2", e.nc2, o_node_coord_2);
                check_field("node_coord_3", e.nc3, o_node_coord_3);
                check_field("out_of_range", e.bad, o_out_of_range);
            end
        end
    end

    // Watchdog on cycles in which no beat moves.
    always @(posedge i_clk) begin
        if ((i_start && !o_busy) || o_done || (i_cfg_valid && o_cfg_ready) || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Present one item and hold it until accepted; start stays high afterwards.
    task automatic send_site(input int c0, input int c1, input int c2, input int c3);
        i_start   <= 1'b1;
        i_coord_0 <= CW'(c0);
        i_coord_1 <= CW'(c1);
        i_coord_2 <= CW'(c2);
        i_coord_3 <= CW'(c3);
        do @(posedge i_clk); while (o_busy);
    endtask

    task automatic pause_sender(input int cycles);
        i_start <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // Stop sending and let every outstanding result arrive.
    task automatic drain;
        i_start <= 1'b0;
        @(posedge i_clk);
        while (pending_sites.size() != 0) @(posedge i_clk);
        repeat (LATENCY_WAIT) @(posedge i_clk);
    endtask

    // One register write, then an idle wait so the shadow copy has settled.
    task automatic write_reg(input logic [2:0] idx, input int value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= SW'(value);
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_all_sizes(input int sg, input int ms);
        for (int d = 0; d < MAX_DIMS; d++) begin
            write_reg(REG_SUBGRID_0 + 3'(d), sg);
            write_reg(REG_MACHINE_0 + 3'(d), ms);
        end
    endtask

    // Random coordinate: mostly inside the lattice, sometimes at or past its edge.
    function automatic int pick_coord(input int d);
        int ext;
        int roll;
        ext = extent_of(d);
        roll = $urandom_range(0, 99);
        if (roll < 4 && ext < 4096) return ext;
        if (roll < 8) return $urandom_range(0, 4095);
        if (roll < 12) return ext - 1;
        return $urandom_range(0, ext - 1);
    endfunction

    // Reset sizes of one: only the origin lies inside the lattice.
    task automatic test_reset_sizes;
        send_site(0, 0, 0, 0);
        send_site(1, 0, 0, 0);
        send_site(0, 0, 0, 4095);
        drain();
    endtask

    // Largest lattice: every coordinate is inside, extremes of the fields; then clamped sizes.
    task automatic test_full_extent;
        set_all_sizes(64, 64);
        send_site(0, 0, 0, 0);
        send_site(4095, 4095, 4095, 4095);
        send_site(4095, 0, 4095, 0);
        send_site(63, 64, 2047, 2048);
        send_site(2730, 1365, 3003, 1092);
        drain();
        // Zero acts as one and values above 64 act as 64.
        set_all_sizes(0, 127);
        send_site(63, 0, 0, 0);
        send_site(64, 0, 0, 0);
        send_site(0, 0, 0, 63);
        drain();
        set_all_sizes(127, 0);
        send_site(4095, 0, 0, 0);
        send_site(63, 63, 63, 63);
        send_site(0, 64, 0, 0);
        drain();
    endtask

    // Coordinates at and just below the extent of each dimension.
    task automatic test_lattice_edge;
        int c [MAX_DIMS];
        write_reg(REG_SUBGRID_0, 3);  write_reg(REG_MACHINE_0, 5);
        write_reg(REG_SUBGRID_0 + 3'd1, 7);  write_reg(REG_MACHINE_0 + 3'd1, 2);
        write_reg(REG_SUBGRID_0 + 3'd2, 1);  write_reg(REG_MACHINE_0 + 3'd2, 64);
        write_reg(REG_SUBGRID_0 + 3'd3, 64); write_reg(REG_MACHINE_0 + 3'd3, 1);
        for (int d = 0; d < MAX_DIMS; d++) begin
            for (int k = 0; k < MAX_DIMS; k++) c[k] = extent_of(k) - 1;
            send_site(c[0], c[1], c[2], c[3]);
            c[d] = extent_of(d);
            send_site(c[0], c[1], c[2], c[3]);
        end
        drain();
    endtask

    // Random sizes per phase, random sites in bursts with random gaps.
    task automatic test_random_sites;
        int left;
        int burst;
        for (int phase = 0; phase < 12; phase++) begin
            for (int r = 0; r < NUM_REGS; r++) begin
                if ($urandom_range(0, 9) == 0)
                    write_reg(3'(r), $urandom_range(0, 127));
                else if ($urandom_range(0, 3) == 0)
                    write_reg(3'(r), $urandom_range(1, 4));
                else
                    write_reg(3'(r), $urandom_range(1, 64));
            end
            left = 140;
            while (left > 0) begin
                burst = $urandom_range(1, 30);
                for (int k = 0; k < burst && left > 0; k++, left--)
                    send_site(pick_coord(0), pick_coord(1), pick_coord(2), pick_coord(3));
                if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 20));
            end
            drain();
        end
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_sizes();
        test_full_extent();
        test_lattice_edge();
        test_random_sites();
        if (error_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
